### hw/rtl/dsbg_pkg.sv
// Shared constants, types and the quarter-wave sine ROM contents for the
// decaying sine burst generator. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dsbg_pkg;

	// Quarter-wave table depth; must be a power of two.
	localparam int SINE_DEPTH   = 1024;
	localparam int SINE_ADDR_W  = $clog2(SINE_DEPTH) + 1;
	localparam int SINE_OFF_W   = $clog2(SINE_DEPTH);
	localparam int PHASE_IDX_W  = SINE_OFF_W + 2;
	localparam int MAX_CHANNELS = 8;
	localparam int RESULT_LIMIT = 8;
	localparam int CH_CAP       = (MAX_CHANNELS < RESULT_LIMIT) ? MAX_CHANNELS : RESULT_LIMIT;

	localparam logic [23:0] ENV_ONE       = 24'hFFFFFF;
	localparam logic [23:0] DECAY_RESET   = 24'd16775468;
	localparam logic [3:0]  CHANNEL_RESET = 4'd2;

	localparam logic OP_TICK    = 1'b0;
	localparam logic OP_TRIGGER = 1'b1;

	localparam logic [1:0] CFG_DECAY    = 2'd0;
	localparam logic [1:0] CFG_CHANNELS = 2'd1;

	localparam logic signed [63:0] Q30_A1 = 64'sd1686629713;
	localparam logic signed [63:0] Q30_A3 = -64'sd693598669;
	localparam logic signed [63:0] Q30_A5 = 64'sd85569306;
	localparam logic signed [63:0] Q30_A7 = -64'sd5026995;
	localparam logic signed [63:0] Q30_A9 = 64'sd172272;

	typedef logic [22:0] sine_rom_t [SINE_DEPTH + 1];

	// Beat handed from the phase/envelope stage to the scaling stage.
	typedef struct packed {
		logic [22:0] mag;
		logic        neg;
		logic [23:0] env;
		logic        active;
	} voice_beat_t;

	// Sign-magnitude Q30 product, truncated toward zero.
	function automatic logic signed [63:0] mul_q30(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic        neg;
		logic [63:0] ma;
		logic [63:0] mb;
		logic [63:0] m;
		neg = a[63] ^ b[63];
		ma  = a[63] ? (64'd0 - a) : a;
		mb  = b[63] ? (64'd0 - b) : b;
		m   = (ma * mb) >> 30;
		return neg ? -$signed(m) : $signed(m);
	endfunction

	function automatic sine_rom_t sine_rom_build();
		sine_rom_t               t;
		logic signed [63:0]      u;
		logic signed [63:0]      u2;
		logic signed [63:0]      p;
		logic signed [63:0]      s;
		for (int k = 0; k <= SINE_DEPTH; k++) begin
			u  = (64'(k) <<< 30) / SINE_DEPTH;
			u2 = mul_q30(u, u);
			p  = Q30_A9;
			p  = Q30_A7 + mul_q30(p, u2);
			p  = Q30_A5 + mul_q30(p, u2);
			p  = Q30_A3 + mul_q30(p, u2);
			p  = Q30_A1 + mul_q30(p, u2);
			s  = mul_q30(p, u);
			if (s < 0)
				s = 64'sd0;
			s = (s + 64'sd64) >>> 7;
			if (s > 64'sd8388607)
				s = 64'sd8388607;
			t[k] = s[22:0];
		end
		return t;
	endfunction

	localparam sine_rom_t SINE_ROM = sine_rom_build();

	// Channels per frame: zero means two, then cap.
	function automatic logic [3:0] channels_eff(input logic [3:0] cc);
		logic [3:0] c;
		c = (cc == 4'd0) ? 4'd2 : cc;
		if (c > 4'(CH_CAP))
			c = 4'(CH_CAP);
		return c;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/dsbg_voice.sv
// Burst state (phase, envelope, position) and the sine ROM read stage.
// Depends on dsbg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dsbg_voice (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_stall,
	input  wire                  operation,
	input  wire  [31:0]          phase_step,
	input  wire  [23:0]          length_samples,
	input  wire  [23:0]          decay,
	input  wire                  next_free,
	output logic                 beat_valid,
	output dsbg_pkg::voice_beat_t beat
);
	import dsbg_pkg::*;

	logic [31:0] phase_q;
	logic [23:0] env_q;
	logic [23:0] pos_q;
	logic [23:0] len_q;
	logic [31:0] step_q;
	logic        valid_s1;
	logic [22:0] mag_s1;
	logic        neg_s1;
	logic [23:0] env_s1;
	logic        active_s1;

	logic                   accept;
	logic                   tick;
	logic                   active;
	logic [PHASE_IDX_W-1:0] idx;
	logic [SINE_OFF_W-1:0]  off;
	logic [SINE_ADDR_W-1:0] addr;
	logic [47:0]            env_prod;
	logic [48:0]            env_rnd;

	assign in_stall = valid_s1 && !next_free;
	assign accept   = in_valid && !in_stall;
	assign tick     = accept && (operation == OP_TICK);
	assign active   = pos_q < len_q;

	// Quadrant from the top two phase bits; odd quadrants read mirrored.
	assign idx  = phase_q[31 -: PHASE_IDX_W];
	assign off  = idx[SINE_OFF_W-1:0];
	assign addr = idx[SINE_OFF_W] ? (SINE_ADDR_W'(SINE_DEPTH) - {1'b0, off}) : {1'b0, off};

	assign env_prod = 48'(env_q) * 48'(decay);
	assign env_rnd  = {1'b0, env_prod} + (49'd1 << 23);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			env_q   <= '0;
			pos_q   <= 24'd1;
			len_q   <= '0;
			step_q  <= '0;
		end else if (accept) begin
			if (operation == OP_TRIGGER) begin
				step_q  <= phase_step;
				len_q   <= length_samples;
				pos_q   <= '0;
				phase_q <= '0;
				env_q   <= ENV_ONE;
			end else if (active) begin
				phase_q <= phase_q + step_q;
				env_q   <= env_rnd[47:24];
				pos_q   <= pos_q + 24'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick) begin
			valid_s1 <= 1'b1;
		end else if (next_free) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick) begin
			mag_s1    <= SINE_ROM[addr];
			neg_s1    <= idx[PHASE_IDX_W-1];
			env_s1    <= env_q;
			active_s1 <= active;
		end
	end

	assign beat_valid  = valid_s1;
	assign beat.mag    = mag_s1;
	assign beat.neg    = neg_s1;
	assign beat.env    = env_s1;
	assign beat.active = active_s1;

endmodule

`default_nettype wire

### hw/rtl/dsbg_scale.sv
// Envelope times sine magnitude, rounded to Q3.21 with the sign applied.
// Depends on dsbg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dsbg_scale (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   beat_valid,
	input  dsbg_pkg::voice_beat_t beat,
	output logic                  free,
	input  wire                   next_free,
	output logic                  sample_valid,
	output logic [23:0]           sample_value
);
	import dsbg_pkg::*;

	logic        valid_s2;
	logic [23:0] sample_s2;

	logic [47:0] prod;
	logic [47:0] rnd;
	logic [23:0] mag;
	logic [23:0] signed_val;

	assign free = !valid_s2 || next_free;

	assign prod       = 48'(beat.env) * 48'(beat.mag);
	assign rnd        = prod + (48'd1 << 25);
	assign mag        = 24'(rnd[47:26]);
	assign signed_val = beat.neg ? (24'd0 - mag) : mag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (free) begin
			valid_s2 <= beat_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (free && beat_valid) begin
			sample_s2 <= beat.active ? signed_val : 24'd0;
		end
	end

	assign sample_valid = valid_s2;
	assign sample_value = sample_s2;

endmodule

`default_nettype wire

### hw/rtl/dsbg_frame_out.sv
// Frame register that copies one sample to each channel, one beat each.
// Depends on dsbg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dsbg_frame_out (
	input  wire         clk,
	input  wire         arst_n,
	input  wire  [3:0]  channel_count,
	input  wire         sample_valid,
	input  wire  [23:0] sample_value,
	output logic        free,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [23:0] sample,
	output logic [2:0]  channel_index,
	output logic        last_in_frame
);
	import dsbg_pkg::*;

	logic        valid_q;
	logic [2:0]  chan_q;
	logic [23:0] sample_q;

	logic        out_accept;
	logic [3:0]  ch;
	logic        last;
	logic        load;

	assign ch         = channels_eff(channel_count);
	assign last       = ({1'b0, chan_q} + 4'd1) == ch;
	assign out_accept = valid_q && !out_stall;
	assign free       = !valid_q || (out_accept && last);
	assign load       = sample_valid && free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			chan_q  <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			chan_q  <= '0;
		end else if (out_accept) begin
			// drop the frame after its last copy, else advance
			if (last)
				valid_q <= 1'b0;
			else
				chan_q <= chan_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			sample_q <= sample_value;
	end

	assign out_valid     = valid_q;
	assign sample        = sample_q;
	assign channel_index = chan_q;
	assign last_in_frame = last;

endmodule

`default_nettype wire

### hw/rtl/decaying_sine_burst_generator_unit.sv
// Top level of the decaying sine burst generator: configuration registers
// and the three-stage path. Depends on dsbg_pkg, dsbg_voice, dsbg_scale, dsbg_frame_out.
`timescale 1ns / 1ps
`default_nettype none

// A trigger beat loads a phase step and a burst length and restarts the
// burst; a tick beat yields one frame, a sample copied to each channel
// (1 to 8 output beats, last_in_frame on the final one). Input beats are
// taken one per cycle while in_stall is low; a trigger only updates the
// burst state, while a tick also passes down the path and then holds the
// single output port for one beat per channel, so that port sets the
// sustained tick rate. A tick passes the ROM read stage and the
// envelope multiply stage before its first copy appears. Up to two ticks
// can be queued in the stages while a frame is still being sent.
// Configuration writes are plain strobes and must only happen while idle.
module decaying_sine_burst_generator_unit (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire  [1:0]  cfg_index,
	input  wire  [23:0] cfg_data,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire         operation,
	input  wire  [31:0] phase_step,
	input  wire  [23:0] length_samples,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [23:0] sample,
	output logic [2:0]  channel_index,
	output logic        last_in_frame
);
	import dsbg_pkg::*;

	logic [23:0] decay_q;
	logic [3:0]  chan_count_q;

	voice_beat_t voice_beat;
	logic        voice_valid;
	logic        scale_free;
	logic        scale_valid;
	logic [23:0] scale_sample;
	logic        frame_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decay_q      <= DECAY_RESET;
			chan_count_q <= CHANNEL_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DECAY:    decay_q      <= cfg_data;
				CFG_CHANNELS: chan_count_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	dsbg_voice u_voice (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.operation      (operation),
		.phase_step     (phase_step),
		.length_samples (length_samples),
		.decay          (decay_q),
		.next_free      (scale_free),
		.beat_valid     (voice_valid),
		.beat           (voice_beat)
	);

	dsbg_scale u_scale (
		.clk          (clk),
		.arst_n       (arst_n),
		.beat_valid   (voice_valid),
		.beat         (voice_beat),
		.free         (scale_free),
		.next_free    (frame_free),
		.sample_valid (scale_valid),
		.sample_value (scale_sample)
	);

	dsbg_frame_out u_frame (
		.clk           (clk),
		.arst_n        (arst_n),
		.channel_count (chan_count_q),
		.sample_valid  (scale_valid),
		.sample_value  (scale_sample),
		.free          (frame_free),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.sample        (sample),
		.channel_index (channel_index),
		.last_in_frame (last_in_frame)
	);

endmodule

`default_nettype wire

### hw/rtl/dsbg_checker.sv
// Port-level checks on the output beat sequence of the burst generator,
// bound to the top level. Depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

module dsbg_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        cfg_we,
	input wire [1:0]  cfg_index,
	input wire [23:0] cfg_data,
	input wire        in_valid,
	input wire        in_stall,
	input wire        operation,
	input wire [31:0] phase_step,
	input wire [23:0] length_samples,
	input wire        out_valid,
	input wire        out_stall,
	input wire [23:0] sample,
	input wire [2:0]  channel_index,
	input wire        last_in_frame
);

	// hold a stalled beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(sample)
			&& $stable(channel_index) && $stable(last_in_frame))
		else $error("stalled output beat changed");

	// copies within a frame carry the same sample on consecutive channels
	a_next_channel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_in_frame |=> out_valid
			&& channel_index == $past(channel_index) + 3'd1
			&& sample == $past(sample))
		else $error("frame copy out of order");

	// a new frame starts on channel zero
	a_frame_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && last_in_frame |=> !out_valid || channel_index == 3'd0)
		else $error("frame did not start on channel zero");

	// an edge seen in reset leaves the output idle
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("output valid during reset");

endmodule

bind decaying_sine_burst_generator_unit dsbg_checker u_dsbg_checker (.*);

`default_nettype wire

### bench/tb_top.sv
// Self-checking bench for decaying_sine_burst_generator_unit: a directed table,
// then random trigger/tick traffic checked by an in-bench burst synthesizer.
// Depends on dsbg_pkg for the operation and register codes.
`timescale 1ns / 1ps

module tb_top;
	import dsbg_pkg::*;

	localparam int          QW_DEPTH       = 1024;
	localparam int          FRAME_CAP      = 8;
	localparam logic [23:0] FULL_ENV       = 24'hFFFFFF;
	localparam logic [23:0] DECAY_AT_RESET = 24'd16775468;
	localparam logic [3:0]  CHANS_AT_RESET = 4'd2;
	localparam logic [1:0]  CFG_UNUSED_2   = 2'd2;
	localparam logic [1:0]  CFG_UNUSED_3   = 2'd3;
	localparam longint      POLY_A1        = 1686629713;
	localparam longint      POLY_A3        = -693598669;
	localparam longint      POLY_A5        = 85569306;
	localparam longint      POLY_A7        = -5026995;
	localparam longint      POLY_A9        = 172272;
	localparam int          SETTLE_CYCLES  = 8;
	localparam int          HOLD_CYCLES    = 150;
	localparam int          QUIET_LIMIT    = 4000;
	localparam int          BEATS_PER_SET  = 19;

	typedef enum logic { ROW_BEAT, ROW_REG } row_kind_t;

	typedef struct {
		row_kind_t   kind;
		logic [1:0]  reg_idx;
		logic [23:0] reg_val;
		logic        op;
		logic [31:0] step;
		logic [23:0] len;
		bit          lit_en;
		logic [23:0] lit;
	} plan_row_t;

	typedef struct {
		logic [23:0] smp;
		logic [2:0]  chan;
		logic        last;
	} copy_t;

	logic        clk            = 1'b0;
	logic        arst_n         = 1'b0;
	logic        cfg_we         = 1'b0;
	logic [1:0]  cfg_index      = '0;
	logic [23:0] cfg_data       = '0;
	logic        in_valid       = 1'b0;
	logic        operation      = 1'b0;
	logic [31:0] phase_step     = '0;
	logic [23:0] length_samples = '0;
	logic        out_stall      = 1'b0;
	logic        in_stall;
	logic        out_valid;
	logic [23:0] sample;
	logic [2:0]  channel_index;
	logic        last_in_frame;

	// burst synthesizer state
	logic [22:0] quarter_wave [0:QW_DEPTH];
	logic [31:0] phase_acc;
	logic [23:0] env_level;
	logic [23:0] burst_pos;
	logic [23:0] burst_len;
	logic [31:0] step_now;
	logic [23:0] decay_now;
	logic [3:0]  chans_now;

	copy_t       frame_copies_q [$];
	plan_row_t   plan [$];

	int  errors      = 0;
	int  beats_in    = 0;
	int  triggers    = 0;
	int  copies_seen = 0;
	int  reg_writes  = 0;
	int  quiet       = 0;
	bit  steady      = 1'b0;
	bit  hold_ask    = 1'b0;
	bit  hold_done   = 1'b0;

	decaying_sine_burst_generator_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.operation      (operation),
		.phase_step     (phase_step),
		.length_samples (length_samples),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.sample         (sample),
		.channel_index  (channel_index),
		.last_in_frame  (last_in_frame)
	);

	always #5 clk = ~clk;

	function automatic longint q30_product(input longint a, input longint b);
		longint unsigned ma;
		longint unsigned mb;
		longint          m;
		ma = (a < 0) ? longint'(-a) : a;
		mb = (b < 0) ? longint'(-b) : b;
		m  = longint'((ma * mb) >> 30);
		return ((a < 0) != (b < 0)) ? -m : m;
	endfunction

	task automatic build_quarter_wave();
		longint u;
		longint u2;
		longint p;
		longint s;
		for (int k = 0; k <= QW_DEPTH; k++) begin
			u  = (longint'(k) << 30) / QW_DEPTH;
			u2 = q30_product(u, u);
			p  = POLY_A9;
			p  = POLY_A7 + q30_product(p, u2);
			p  = POLY_A5 + q30_product(p, u2);
			p  = POLY_A3 + q30_product(p, u2);
			p  = POLY_A1 + q30_product(p, u2);
			s  = q30_product(p, u);
			if (s < 0)
				s = 0;
			s = (s + 64) >>> 7;
			if (s > 8388607)
				s = 8388607;
			quarter_wave[k] = s[22:0];
		end
	endtask

	// Advance the burst by one accepted beat and queue the copies it yields.
	task automatic synth_frame(input logic op, input logic [31:0] st, input logic [23:0] ln,
		input bit lit_en, input logic [23:0] lit);
		logic [23:0]     word;
		logic [11:0]     idx;
		logic [22:0]     mag;
		longint unsigned scaled;
		int              n;
		copy_t           c;
		if (op == OP_TRIGGER) begin
			step_now  = st;
			burst_len = ln;
			burst_pos = '0;
			phase_acc = '0;
			env_level = FULL_ENV;
			triggers++;
			return;
		end
		word = '0;
		if (burst_pos < burst_len) begin
			idx    = phase_acc[31:20];
			mag    = idx[10] ? quarter_wave[QW_DEPTH - int'(idx[9:0])] : quarter_wave[idx[9:0]];
			scaled = (longint'(env_level) * longint'(mag) + 64'd33554432) >> 26;
			word   = idx[11] ? 24'(64'd0 - scaled) : scaled[23:0];
			phase_acc = phase_acc + step_now;
			env_level = 24'((longint'(env_level) * longint'(decay_now) + 64'd8388608) >> 24);
			burst_pos = burst_pos + 24'd1;
		end
		if (lit_en)
			word = lit;
		n = (chans_now == 4'd0) ? 2 : int'(chans_now);
		if (n > FRAME_CAP)
			n = FRAME_CAP;
		for (int i = 0; i < n; i++) begin
			c.smp  = word;
			c.chan = 3'(i);
			c.last = (i == n - 1);
			frame_copies_q.push_back(c);
		end
	endtask

	function automatic int gap_cycles();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic plan_row_t beat_row(input logic op, input logic [31:0] st,
		input logic [23:0] ln, input bit lit_en);
		plan_row_t r;
		r.kind    = ROW_BEAT;
		r.reg_idx = '0;
		r.reg_val = '0;
		r.op      = op;
		r.step    = st;
		r.len     = ln;
		r.lit_en  = lit_en;
		r.lit     = '0;
		return r;
	endfunction

	function automatic plan_row_t reg_row(input logic [1:0] idx, input logic [23:0] val);
		plan_row_t r;
		r         = beat_row(OP_TICK, '0, '0, 1'b0);
		r.kind    = ROW_REG;
		r.reg_idx = idx;
		r.reg_val = val;
		return r;
	endfunction

	task automatic offer_beat(input logic op, input logic [31:0] st, input logic [23:0] ln,
		input bit lit_en, input logic [23:0] lit);
		int gap;
		gap = steady ? 0 : gap_cycles();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid       <= 1'b1;
		operation      <= op;
		phase_step     <= st;
		length_samples <= ln;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		synth_frame(op, st, ln, lit_en, lit);
		beats_in++;
	endtask

	// Drop valid and wait until every queued copy is out and the pipe is empty.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (frame_copies_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_DECAY:    decay_now = val;
			CFG_CHANNELS: chans_now = val[3:0];
			default: ;
		endcase
		reg_writes++;
		@(posedge clk);
	endtask

	// Receiver: random stalls, one long hold-off on request.
	initial begin
		int run;
		@(posedge clk);
		forever begin
			if (hold_ask && !hold_done) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
				out_stall <= 1'b0;
				@(posedge clk);
			end else begin
				run = steady ? 0 : gap_cycles();
				if (run > 0) begin
					out_stall <= 1'b1;
					repeat (run) @(posedge clk);
				end
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin : check_out
		copy_t want;
		if (arst_n && out_valid && !out_stall) begin
			copies_seen++;
			if (frame_copies_q.size() == 0) begin
				if (errors < 10)
					$display("Unexpected output beat: sample %0d channel %0d last %0b",
						$signed(sample), channel_index, last_in_frame);
				errors++;
			end else begin
				want = frame_copies_q.pop_front();
				if (want.smp !== sample || want.chan !== channel_index
					|| want.last !== last_in_frame) begin
					if (errors < 10)
						$display({"Mismatch at copy %0d: sample exp %0d got %0d, ",
							"channel exp %0d got %0d, last exp %0b got %0b"},
							copies_seen, $signed(want.smp), $signed(sample), want.chan,
							channel_index, want.last, last_in_frame);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
			quiet <= 0;
		end else if (quiet == QUIET_LIMIT) begin
			$display("Watchdog: no beat moved for %0d cycles", QUIET_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin
		int          r;
		logic [23:0] ln;

		build_quarter_wave();
		phase_acc = '0;
		env_level = '0;
		burst_pos = 24'd1;
		burst_len = '0;
		step_now  = '0;
		decay_now = DECAY_AT_RESET;
		chans_now = CHANS_AT_RESET;

		// directed: zeros are read off directly, the rest comes from the synthesizer
		plan.push_back(beat_row(OP_TICK, 32'hFFFFFFFF, 24'hFFFFFF, 1'b1));
		plan.push_back(reg_row(CFG_CHANNELS, 24'd0));
		plan.push_back(beat_row(OP_TRIGGER, 32'h40000000, 24'd0, 1'b0));
		plan.push_back(beat_row(OP_TICK, 32'h0, 24'h0, 1'b1));
		plan.push_back(beat_row(OP_TRIGGER, 32'hFFFFFFFF, 24'd3, 1'b0));
		plan.push_back(beat_row(OP_TICK, 32'h0, 24'h0, 1'b1));
		plan.push_back(beat_row(OP_TICK, 32'h0, 24'h0, 1'b0));
		plan.push_back(beat_row(OP_TICK, 32'h0, 24'h0, 1'b0));
		plan.push_back(beat_row(OP_TICK, 32'h0, 24'h0, 1'b1));
		plan.push_back(reg_row(CFG_CHANNELS, 24'd15));
		plan.push_back(reg_row(CFG_DECAY, 24'd0));
		plan.push_back(beat_row(OP_TRIGGER, 32'h12345678, 24'hFFFFFF, 1'b0));
		plan.push_back(beat_row(OP_TICK, 32'h0, 24'h0, 1'b1));
		plan.push_back(beat_row(OP_TICK, 32'h0, 24'h0, 1'b1));
		plan.push_back(reg_row(CFG_DECAY, 24'hFFFFFF));
		plan.push_back(reg_row(CFG_CHANNELS, 24'd1));
		plan.push_back(reg_row(CFG_UNUSED_2, 24'hFFFFFF));
		plan.push_back(reg_row(CFG_UNUSED_3, 24'd1));
		plan.push_back(beat_row(OP_TRIGGER, 32'h40000000, 24'd5, 1'b0));
		plan.push_back(beat_row(OP_TICK, 32'h0, 24'h0, 1'b1));
		plan.push_back(beat_row(OP_TICK, 32'h0, 24'h0, 1'b0));
		plan.push_back(beat_row(OP_TICK, 32'h0, 24'h0, 1'b0));
		plan.push_back(beat_row(OP_TICK, 32'h0, 24'h0, 1'b0));
		plan.push_back(beat_row(OP_TICK, 32'h0, 24'h0, 1'b0));
		plan.push_back(beat_row(OP_TICK, 32'h0, 24'h0, 1'b1));
		plan.push_back(reg_row(CFG_CHANNELS, 24'd9));
		plan.push_back(beat_row(OP_TRIGGER, 32'hAAAAAAAA, 24'h800000, 1'b0));
		plan.push_back(beat_row(OP_TICK, 32'h0, 24'h0, 1'b1));
		plan.push_back(beat_row(OP_TICK, 32'h0, 24'h0, 1'b0));
		plan.push_back(reg_row(CFG_CHANNELS, 24'd8));
		plan.push_back(beat_row(OP_TRIGGER, 32'h0, 24'd1, 1'b0));
		plan.push_back(beat_row(OP_TICK, 32'h0, 24'h0, 1'b1));
		plan.push_back(beat_row(OP_TICK, 32'h0, 24'h0, 1'b1));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < plan.size(); i++) begin
			if (plan[i].kind == ROW_REG) begin
				settle();
				write_reg(plan[i].reg_idx, plan[i].reg_val);
			end else begin
				offer_beat(plan[i].op, plan[i].step, plan[i].len, plan[i].lit_en, plan[i].lit);
			end
		end

		// random bursts under four register settings
		for (int set = 0; set < 4; set++) begin
			settle();
			case (set)
				0: begin
					write_reg(CFG_DECAY, DECAY_AT_RESET);
					write_reg(CFG_CHANNELS, 24'd2);
				end
				1: begin
					write_reg(CFG_DECAY, 24'($urandom));
					write_reg(CFG_CHANNELS, 24'($urandom));
				end
				2: begin
					write_reg(CFG_DECAY, 24'($urandom_range(16000000, 16777215)));
					write_reg(CFG_CHANNELS, 24'd8);
				end
				default: begin
					write_reg(CFG_DECAY, 24'($urandom_range(15000000, 16777215)));
					write_reg(CFG_CHANNELS, 24'($urandom_range(3, 7)));
				end
			endcase
			steady = (set == 2);
			for (int k = 0; k < BEATS_PER_SET; k++) begin
				if (set == 1 && k == 8)
					hold_ask = 1'b1;
				if (set == 3 && k == 12)
					settle();
				r = $urandom_range(0, 99);
				if (k == 0 || r < 15) begin
					r = $urandom_range(0, 99);
					if (r < 70)
						ln = 24'($urandom_range(1, 40));
					else if (r < 85)
						ln = 24'($urandom_range(0, 2));
					else
						ln = 24'($urandom);
					offer_beat(OP_TRIGGER, $urandom, ln, 1'b0, '0);
				end else begin
					offer_beat(OP_TICK, $urandom, 24'($urandom), 1'b0, '0);
				end
			end
		end
		steady = 1'b0;

		settle();
		repeat (20) @(posedge clk);
		if (frame_copies_q.size() != 0) begin
			$display("%0d expected copies never arrived", frame_copies_q.size());
			errors += frame_copies_q.size();
		end

		$display("Sent %0d input beats (%0d triggers) across %0d register writes;",
			beats_in, triggers, reg_writes);
		$display("checked %0d output copies, %0d failures.", copies_seen, errors);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
